// ----- sv/salts_pkg.sv -----
// ----------------------------------------------------------------------------
// salts_pkg: shared types and codes for the LRU tag store
// Operation codes, outcome codes and the front-to-back request word.
// ----------------------------------------------------------------------------
`default_nettype none
package salts_pkg;
  localparam int unsigned ADDR_W = 32;
  localparam int unsigned OUTCOME_W = 2;
  localparam int unsigned WAY_OUT_W = 2;

  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_FILL = 1'b1;

  localparam logic [OUTCOME_W-1:0] OUT_HIT = 2'd0;
  localparam logic [OUTCOME_W-1:0] OUT_MISS_WAIT = 2'd1;
  localparam logic [OUTCOME_W-1:0] OUT_MISS_FWD = 2'd2;
  localparam logic [OUTCOME_W-1:0] OUT_FILL_DONE = 2'd3;

  typedef struct packed {
    logic              op;
    logic              pending;
    logic [ADDR_W-1:0] addr;
  } req_t;
endpackage
`default_nettype wire

// ----- sv/salts_front.sv -----
// ----------------------------------------------------------------------------
// salts_front: request intake and queue
// Accept items and hold them in a short FIFO for the execution side.
// ----------------------------------------------------------------------------
`default_nettype none
module salts_front #(
  parameter int unsigned DEPTH = 2
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_ready,
  input  salts_pkg::req_t     in_req,
  output logic                q_valid,
  input  wire                 q_ready,
  output salts_pkg::req_t     q_req
);
  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  salts_pkg::req_t mem_r [DEPTH];
  logic [PW-1:0] wp_r, rp_r;
  logic [CW-1:0] cnt_r;
  logic push, pop;

  assign in_ready = (cnt_r != CW'(DEPTH));
  assign q_valid = (cnt_r != '0);
  assign q_req = mem_r[rp_r];
  assign push = in_valid && in_ready;
  assign pop = q_valid && q_ready;

  function automatic logic [PW-1:0] inc(input logic [PW-1:0] p);
    if (p == PW'(DEPTH - 1)) inc = '0;
    else inc = p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= in_req;
    end
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= inc(wp_r);
      if (pop) rp_r <= inc(rp_r);
      if (push && !pop) cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end
endmodule
`default_nettype wire

// ----- sv/salts_back.sv -----
// ----------------------------------------------------------------------------
// salts_back: tag compare, LRU update and result register
// Read the set as a request is taken, pass a wait state, then decide and write back.
// ----------------------------------------------------------------------------
`default_nettype none
module salts_back #(
  parameter int unsigned SETS = 64,
  parameter int unsigned WAYS = 4,
  parameter int unsigned BLOCK_BYTES = 32
) (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire                                  q_valid,
  output logic                                 q_ready,
  input  salts_pkg::req_t                      q_req,
  output logic                                 out_valid,
  input  wire                                  out_ready,
  output logic [salts_pkg::OUTCOME_W-1:0]      out_outcome,
  output logic [salts_pkg::WAY_OUT_W-1:0]      out_way
);
  localparam int unsigned BB = $clog2(BLOCK_BYTES);
  localparam int unsigned SB = $clog2(SETS);
  localparam int unsigned SW = (SB > 0) ? SB : 1;
  localparam int unsigned TW = salts_pkg::ADDR_W - BB - SB;
  localparam int unsigned WW = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int unsigned AW = WW;
  localparam logic [AW-1:0] AMAX = AW'(WAYS - 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_READ = 2'd1;
  localparam logic [1:0] ST_EXEC = 2'd2;
  localparam logic [1:0] ST_OUT = 2'd3;

  logic [1:0] st_r, st_nxt;
  logic [WAYS*TW-1:0] tag_mem [SETS];
  logic [WAYS*AW-1:0] age_mem [SETS];
  logic [WAYS-1:0] valid_r [SETS];
  logic [WAYS*TW-1:0] rtag_r;
  logic [WAYS*AW-1:0] rage_r;
  logic [WAYS-1:0] rvld_r;
  salts_pkg::req_t req_r;
  logic [salts_pkg::OUTCOME_W-1:0] outcome_r;
  logic [salts_pkg::WAY_OUT_W-1:0] way_r;

  logic [SW-1:0] set_q, set_r;
  logic [TW-1:0] tag_r;
  logic [WAYS-1:0] vld, hitv;
  logic hit, found;
  logic [WW-1:0] hit_w, inv_w, old_w, tgt_w;
  logic [AW-1:0] old_a, prev_a;
  logic [WAYS*AW-1:0] nage;
  logic do_write;

  always_comb begin
    set_q = '0;
    set_r = '0;
    if (SB > 0) begin
      set_q = SW'(q_req.addr >> BB);
      set_r = SW'(req_r.addr >> BB);
    end
  end
  assign tag_r = TW'(req_r.addr >> (BB + SB));
  assign vld = rvld_r;

  always_comb begin
    hit = 1'b0;
    hit_w = '0;
    found = 1'b0;
    inv_w = '0;
    old_w = '0;
    old_a = rage_r[AW-1:0];
    for (int b = 0; b < WAYS; b++) begin
      hitv[b] = vld[b] && (rtag_r[b*TW +: TW] == tag_r);
      if (hitv[b] && !hit) begin
        hit = 1'b1;
        hit_w = WW'(b);
      end
      if (!vld[b] && !found) begin
        found = 1'b1;
        inv_w = WW'(b);
      end
      if (b > 0 && rage_r[b*AW +: AW] > old_a) begin
        old_a = rage_r[b*AW +: AW];
        old_w = WW'(b);
      end
    end
  end

  always_comb begin
    if (req_r.op == salts_pkg::OP_LOOKUP) tgt_w = hit_w;
    else if (found) tgt_w = inv_w;
    else tgt_w = old_w;
    prev_a = rage_r[tgt_w*AW +: AW];
    nage = rage_r;
    for (int b = 0; b < WAYS; b++) begin
      if (WW'(b) == tgt_w) begin
        nage[b*AW +: AW] = '0;
      end else if (vld[b]) begin
        if (req_r.op == salts_pkg::OP_FILL && found) begin
          if (rage_r[b*AW +: AW] < AMAX) nage[b*AW +: AW] = rage_r[b*AW +: AW] + 1'b1;
        end else if (rage_r[b*AW +: AW] < prev_a) begin
          nage[b*AW +: AW] = rage_r[b*AW +: AW] + 1'b1;
        end
      end
    end
  end

  assign do_write = (st_r == ST_EXEC) && (req_r.op == salts_pkg::OP_FILL || hit);
  assign q_ready = (st_r == ST_IDLE);
  assign out_valid = (st_r == ST_OUT);
  assign out_outcome = outcome_r;
  assign out_way = way_r;

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE: if (q_valid) st_nxt = ST_READ;
      ST_READ: st_nxt = ST_EXEC;
      ST_EXEC: st_nxt = ST_OUT;
      ST_OUT: if (out_ready) st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (q_valid && q_ready) req_r <= q_req;
    if (st_r == ST_IDLE) begin
      rtag_r <= tag_mem[set_q];
      rage_r <= age_mem[set_q];
      rvld_r <= valid_r[set_q];
    end
    if (do_write) begin
      age_mem[set_r] <= nage;
      if (req_r.op == salts_pkg::OP_FILL) begin
        tag_mem[set_r][tgt_w*TW +: TW] <= tag_r;
      end
    end
    if (st_r == ST_EXEC) begin
      if (req_r.op == salts_pkg::OP_FILL) begin
        outcome_r <= salts_pkg::OUT_FILL_DONE;
        way_r <= salts_pkg::WAY_OUT_W'(tgt_w);
      end else if (hit) begin
        outcome_r <= salts_pkg::OUT_HIT;
        way_r <= salts_pkg::WAY_OUT_W'(tgt_w);
      end else begin
        outcome_r <= req_r.pending ? salts_pkg::OUT_MISS_WAIT : salts_pkg::OUT_MISS_FWD;
        way_r <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      for (int s = 0; s < SETS; s++) valid_r[s] <= '0;
    end else begin
      st_r <= st_nxt;
      if (do_write && req_r.op == salts_pkg::OP_FILL) valid_r[set_r][tgt_w] <= 1'b1;
    end
  end
endmodule
`default_nettype wire

// ----- sv/set_assoc_lru_tag_store_core.sv -----
// ----------------------------------------------------------------------------
// set_assoc_lru_tag_store_core: set-associative tag store with true LRU
// Lookups report hit way or miss kind; fills place a tag by LRU victim.
// ----------------------------------------------------------------------------
// Each word passes through the execution states in order: intake with the
// set read, a wait state, compare with tag, valid and age write-back, and
// the result state, which stretches while the receiver stalls. A two-entry
// queue keeps intake open while a word executes. Valid bits are flip-flops
// cleared by reset, so no clearing pass is needed.
`default_nettype none
module set_assoc_lru_tag_store_core #(
  parameter int unsigned SETS = 64,
  parameter int unsigned WAYS = 4,
  parameter int unsigned BLOCK_BYTES = 32
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire [39:0]  in_tdata,   // [31:0] address, [32] miss_pending
  input  wire         in_tuser,   // [0] operation
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [7:0]  out_tdata,  // [1:0] way
  output logic [1:0]  out_tuser   // [1:0] outcome
);
  salts_pkg::req_t in_req, q_req;
  logic q_valid, q_ready;
  logic [salts_pkg::OUTCOME_W-1:0] outcome;
  logic [salts_pkg::WAY_OUT_W-1:0] way;

  assign in_req.op = in_tuser;
  assign in_req.addr = in_tdata[31:0];
  assign in_req.pending = in_tdata[32];

  salts_front #(.DEPTH(2)) u_front (
    .clk, .rst_n,
    .in_valid(in_tvalid), .in_ready(in_tready), .in_req,
    .q_valid, .q_ready, .q_req
  );

  salts_back #(.SETS(SETS), .WAYS(WAYS), .BLOCK_BYTES(BLOCK_BYTES)) u_back (
    .clk, .rst_n, .q_valid, .q_ready, .q_req,
    .out_valid(out_tvalid), .out_ready(out_tready),
    .out_outcome(outcome), .out_way(way)
  );

  assign out_tdata = {6'b0, way};
  assign out_tuser = outcome;
endmodule
`default_nettype wire

// ----- sv/salts_checker.sv -----
// ----------------------------------------------------------------------------
// salts_checker: port-level checks for the tag store
// Stream stability, result encoding, miss way rule and no result after reset.
// ----------------------------------------------------------------------------
`default_nettype none
module salts_checker (
  input wire        clk,
  input wire        rst_n,
  input wire        out_tvalid,
  input wire        out_tready,
  input wire [7:0]  out_tdata,
  input wire [1:0]  out_tuser
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result dropped while stalled");
  a_pad: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[7:2] == 6'b0)
    else $error("padding bits set");
  a_miss_way: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == salts_pkg::OUT_MISS_WAIT ||
                   out_tuser == salts_pkg::OUT_MISS_FWD)
      |-> out_tdata[1:0] == 2'd0)
    else $error("miss reports nonzero way");
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result after reset");
endmodule

bind set_assoc_lru_tag_store_core salts_checker u_chk (.*);
`default_nettype wire

// ----- tb/sv/set_assoc_lru_tag_store_core_tb.sv -----
// ----------------------------------------------------------------------------
// set_assoc_lru_tag_store_core_tb: self-checking bench for the LRU tag store
// Drives lookup and fill words, predicts outcome and way with a behavioral
// copy of the sets, ways, tags and true LRU ages, and checks every result word
// in order under several sender and receiver idling phases.
// ----------------------------------------------------------------------------
`default_nettype none
module set_assoc_lru_tag_store_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSETS = 64;
  localparam int NWAYS = 4;
  localparam int OFF_BITS = 5;
  localparam int IDX_BITS = 6;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  wire         in_ready;
  logic [39:0] in_data = '0;
  logic        in_user = 1'b0;
  wire         out_valid;
  logic        out_ready = 1'b0;
  wire  [7:0]  out_data;
  wire  [1:0]  out_user;

  set_assoc_lru_tag_store_core uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_valid), .in_tready(in_ready), .in_tdata(in_data), .in_tuser(in_user),
    .out_tvalid(out_valid), .out_tready(out_ready), .out_tdata(out_data),
    .out_tuser(out_user)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  bit          tag_valid [NSETS][NWAYS];
  logic [20:0] tag_val [NSETS][NWAYS];
  logic [1:0]  tag_age [NSETS][NWAYS];
  logic [3:0]  expected_words [$];
  int          errors = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  logic [20:0] hot_tags [NSETS][6];

  function automatic void age_younger(int s, int w);
    logic [1:0] prev;
    prev = tag_age[s][w];
    for (int b = 0; b < NWAYS; b++)
      if (tag_valid[s][b] && tag_age[s][b] < prev) tag_age[s][b]++;
    tag_age[s][w] = 0;
  endfunction

  function automatic logic [3:0] predict_access(logic op, logic [31:0] addr, logic pend);
    int s, victim;
    logic [20:0] tg;
    bit found;
    s = int'(addr[OFF_BITS +: IDX_BITS]);
    tg = addr[31:OFF_BITS+IDX_BITS];
    if (op == salts_pkg::OP_LOOKUP) begin
      for (int b = 0; b < NWAYS; b++)
        if (tag_valid[s][b] && tag_val[s][b] == tg) begin
          age_younger(s, b);
          return {2'(b), salts_pkg::OUT_HIT};
        end
      return {2'd0, pend ? salts_pkg::OUT_MISS_WAIT : salts_pkg::OUT_MISS_FWD};
    end
    found = 0;
    victim = 0;
    for (int b = 0; b < NWAYS; b++)
      if (!found && !tag_valid[s][b]) begin
        victim = b;
        found = 1;
      end
    if (found) begin
      for (int b = 0; b < NWAYS; b++)
        if (b != victim && tag_valid[s][b] && tag_age[s][b] < NWAYS - 1) tag_age[s][b]++;
      tag_age[s][victim] = 0;
    end else begin
      for (int b = 1; b < NWAYS; b++)
        if (tag_age[s][b] > tag_age[s][victim]) victim = b;
      age_younger(s, victim);
    end
    tag_val[s][victim] = tg;
    tag_valid[s][victim] = 1;
    return {2'(victim), salts_pkg::OUT_FILL_DONE};
  endfunction

  task automatic send_word(logic op, logic [31:0] addr, logic pend);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_data <= {7'd0, pend, addr};
    in_user <= op;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_words.push_back(predict_access(op, addr, pend));
    @(negedge clk);
  endtask

  always @(negedge clk)
    out_ready <= ($urandom_range(99) >= recv_stall_pct);

  always @(posedge clk) begin
    logic [3:0] exp_w;
    if (rst_n && out_valid && out_ready) begin
      if (expected_words.size() == 0) begin
        $display("%0t: unexpected word expected=none actual outcome=%0d way=%0d",
                 $time, out_user, out_data[1:0]);
        errors++;
      end else begin
        exp_w = expected_words.pop_front();
        if (out_user !== exp_w[1:0] || out_data[1:0] !== exp_w[3:2]) begin
          $display("%0t: mismatch expected outcome=%0d way=%0d actual outcome=%0d way=%0d",
                   $time, exp_w[1:0], exp_w[3:2], out_user, out_data[1:0]);
          errors++;
        end
      end
    end
  end

  function automatic logic [31:0] make_addr(logic [20:0] tg, int s);
    return {tg, 6'(s), 5'($urandom_range(31))};
  endfunction

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (expected_words.size() != 0) @(negedge clk);
  endtask

  task automatic test_directed();
    send_word(salts_pkg::OP_LOOKUP, 32'h0000_0000, 1'b0);
    send_word(salts_pkg::OP_LOOKUP, 32'hFFFF_FFFF, 1'b1);
    send_word(salts_pkg::OP_FILL, 32'hFFFF_FFFF, 1'b1);
    send_word(salts_pkg::OP_LOOKUP, 32'hFFFF_FFE0, 1'b0);
    for (int i = 0; i < 5; i++) send_word(salts_pkg::OP_FILL, make_addr(21'(i + 1), 3), 1'b0);
    for (int i = 0; i < 6; i++) send_word(salts_pkg::OP_LOOKUP, make_addr(21'(i), 3), i[0]);
    send_word(salts_pkg::OP_FILL, make_addr(21'd2, 3), 1'b1);
    send_word(salts_pkg::OP_LOOKUP, make_addr(21'd2, 3), 1'b0);
    send_word(salts_pkg::OP_FILL, make_addr(21'h1FFFFF, 0), 1'b0);
    send_word(salts_pkg::OP_LOOKUP, 32'h0000_0003, 1'b1);
    wait_drained();
  endtask

  task automatic test_random(int n);
    int s, k;
    logic [31:0] a;
    for (int i = 0; i < n; i++) begin
      s = $urandom_range(7);
      k = $urandom_range(5);
      if ($urandom_range(9) == 0) a = $urandom;
      else a = make_addr(hot_tags[s][k], s);
      send_word($urandom_range(2) == 0 ? salts_pkg::OP_FILL : salts_pkg::OP_LOOKUP, a,
                1'($urandom_range(1)));
    end
  endtask

  initial begin
    for (int s = 0; s < NSETS; s++)
      for (int k = 0; k < 6; k++) hot_tags[s][k] = 21'($urandom);
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_random(180);
    wait_drained();
    send_idle_pct = 78;
    test_random(170);
    send_idle_pct = 0;
    recv_stall_pct = 78;
    test_random(170);
    send_idle_pct = 16;
    recv_stall_pct = 16;
    test_random(170);
    wait_drained();
    recv_stall_pct = 0;
    repeat (20) @(negedge clk);
    if (errors == 0 && expected_words.size() == 0) begin
      $display("set_assoc_lru_tag_store_core_tb: done, clean");
    end else begin
      $display("set_assoc_lru_tag_store_core_tb: done, errors");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("set_assoc_lru_tag_store_core_tb: done, errors");
    $finish;
  end
endmodule
`default_nettype wire
